>>> rtl/write_message_validator_assert.svh
// Assertion macros shared by the validator modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WRITE_MESSAGE_VALIDATOR_ASSERT_SVH
`define WRITE_MESSAGE_VALIDATOR_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define WMV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WMV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WMV_ASSERT_IMP(lbl, ante, cons, msg)
`define WMV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/wmv_pkg.sv
package wmv_pkg;

  // Outcome of a finished message
  typedef enum logic [2:0] {
    KIND_MISMATCH,
    KIND_ODD,
    KIND_RANGE,
    KIND_RAM,
    KIND_FLASH
  } kind_t;

  // Dispatch actions
  localparam logic [2:0] ACT_REJECT      = 3'd0;
  localparam logic [2:0] ACT_RAM_COPY    = 3'd1;
  localparam logic [2:0] ACT_RAM_EXEC    = 3'd2;
  localparam logic [2:0] ACT_FLASH_WRITE = 3'd3;
  localparam logic [2:0] ACT_FLASH_ERASE = 3'd4;

  // Command codes that select the variant actions
  localparam logic [7:0] CMD_EXEC  = 8'h80;
  localparam logic [7:0] CMD_ERASE = 8'h44;

  // Reply bytes
  localparam logic [7:0] RESP_HDR0     = 8'h6D;
  localparam logic [7:0] RESP_HDR1     = 8'hF0;
  localparam logic [7:0] RESP_HDR2     = 8'h10;
  localparam logic [7:0] RESP_FAIL     = 8'h7F;
  localparam logic [7:0] RESP_OK       = 8'h76;
  localparam logic [7:0] RESP_WRITE    = 8'h36;
  localparam logic [7:0] RESP_ODD      = 8'hFF;
  localparam logic [7:0] RESP_RANGE    = 8'hEE;
  localparam logic [7:0] RESP_ZERO     = 8'h00;

  // Run lengths per outcome
  localparam logic [3:0] RUN_MISMATCH = 4'd11;
  localparam logic [3:0] RUN_FAIL     = 4'd7;
  localparam logic [3:0] RUN_RAM      = 4'd4;
  localparam logic [3:0] RUN_FLASH    = 4'd1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RAM_LOW    = 2'd0;
  localparam logic [1:0] CFG_RAM_HIGH   = 2'd1;
  localparam logic [1:0] CFG_FLASH_LOW  = 2'd2;
  localparam logic [1:0] CFG_FLASH_HIGH = 2'd3;

  // Address windows
  typedef struct packed {
    logic [23:0] ram_low;
    logic [23:0] ram_high;
    logic [23:0] flash_low;
    logic [23:0] flash_high;
  } window_t;

  // Verdict handed from parser to reply sequencer
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  action;
    logic [23:0] start;
    logic [15:0] length;
    logic [15:0] sum;
    logic [15:0] expected;
  } verdict_t;

endpackage

>>> rtl/write_message_validator.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    msg_byte, msg_first
// out_      output     out_valid / out_ready  resp_byte, resp_valid, resp_last, action,
//                                             dest_start, dest_length
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One message byte is taken per cycle; the parser updates its state in the same cycle.
// The last checksum byte loads a verdict register; its run of 1 to 11 replies leaves
// the reply sequencer one per cycle while out_ready is high, and the next verdict
// waits behind it. Input stalls only when a second verdict is ready while the first
// run is still out. Reset (rst_n low, synchronous) clears position, captures and both
// valid flags and restores the window registers. cfg_ready is always high.
module write_message_validator import wmv_pkg::*; #(
  parameter logic [15:0] MAX_LEN = 16'd4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_msg_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_resp_byte,
  output logic        out_resp_valid,
  output logic        out_resp_last,
  output logic [2:0]  out_action,
  output logic [23:0] out_dest_start,
  output logic [15:0] out_dest_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  window_t  win_r;
  logic     vrd_valid, vrd_take;
  verdict_t vrd;

  assign cfg_ready = 1'b1;

  // Window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.ram_low    <= 24'hFF8000;
      win_r.ram_high   <= 24'hFFCDFF;
      win_r.flash_low  <= 24'h008000;
      win_r.flash_high <= 24'h020000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RAM_LOW:    win_r.ram_low    <= cfg_data;
        CFG_RAM_HIGH:   win_r.ram_high   <= cfg_data;
        CFG_FLASH_LOW:  win_r.flash_low  <= cfg_data;
        CFG_FLASH_HIGH: win_r.flash_high <= cfg_data;
        default: ;
      endcase
    end
  end

  wmv_parse #(
    .MAX_LEN(MAX_LEN)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_msg_byte  (in_msg_byte),
    .in_msg_first (in_msg_first),
    .win          (win_r),
    .vrd_valid    (vrd_valid),
    .vrd          (vrd),
    .vrd_take     (vrd_take)
  );

  wmv_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .vrd_valid       (vrd_valid),
    .vrd             (vrd),
    .vrd_take        (vrd_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_resp_byte   (out_resp_byte),
    .out_resp_valid  (out_resp_valid),
    .out_resp_last   (out_resp_last),
    .out_action      (out_action),
    .out_dest_start  (out_dest_start),
    .out_dest_length (out_dest_length)
  );

endmodule

>>> rtl/wmv_parse.sv
module wmv_parse import wmv_pkg::*; #(
  parameter logic [15:0] MAX_LEN = 16'd4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_msg_first,
  input  window_t     win,
  output logic        vrd_valid,
  output verdict_t    vrd,
  input  logic        vrd_take
);

`include "write_message_validator_assert.svh"

  logic [16:0] pos_r;
  logic [7:0]  cmd_r;
  logic [15:0] len_r;
  logic [23:0] start_r;
  logic [15:0] sum_r;
  logic [7:0]  exph_r;
  logic [24:0] end_r;
  logic        vld_r;
  verdict_t    vrd_r;

  logic        accept;
  logic [16:0] pos_eff;
  logic [15:0] sum_eff;
  logic [16:0] lim10, lim11, lim12;
  logic        active, sum_en, final_byte, len_ok, ram_ok, flash_ok;
  logic [15:0] sum_nxt, expected;
  verdict_t    vrd_nxt;

  assign in_ready = !vld_r || vrd_take;
  assign accept   = in_valid && in_ready;

  // Restart position and sum on a first mark
  assign pos_eff = in_msg_first ? 17'd0 : pos_r;
  assign sum_eff = in_msg_first ? 16'd0 : sum_r;

  assign lim10 = {1'b0, len_r} + 17'd10;
  assign lim11 = {1'b0, len_r} + 17'd11;
  assign lim12 = {1'b0, len_r} + 17'd12;

  assign active     = pos_eff < lim12;
  assign sum_en     = (pos_eff >= 17'd4) && (pos_eff < lim10);
  assign final_byte = active && (pos_eff == lim11);
  assign sum_nxt    = sum_eff + (sum_en ? {8'd0, in_msg_byte} : 16'd0);
  assign expected   = {exph_r, in_msg_byte};

  // Window checks at the last checksum byte
  assign len_ok   = len_r <= MAX_LEN;
  assign ram_ok   = len_ok && (start_r >= win.ram_low) && (end_r <= {1'b0, win.ram_high});
  assign flash_ok = len_ok && (start_r >= win.flash_low)
                    && (end_r <= {1'b0, win.flash_high});

  always_comb begin
    vrd_nxt.sum      = sum_eff;
    vrd_nxt.expected = expected;
    vrd_nxt.length   = len_r;
    vrd_nxt.start    = start_r;
    vrd_nxt.action   = ACT_REJECT;
    if (sum_eff != expected) begin
      vrd_nxt.kind = KIND_MISMATCH;
    end else if (start_r[0]) begin
      vrd_nxt.kind = KIND_ODD;
    end else if (ram_ok) begin
      vrd_nxt.kind   = KIND_RAM;
      vrd_nxt.action = (cmd_r == CMD_EXEC) ? ACT_RAM_EXEC : ACT_RAM_COPY;
    end else if (flash_ok) begin
      vrd_nxt.kind   = KIND_FLASH;
      vrd_nxt.action = (cmd_r == CMD_ERASE) ? ACT_FLASH_ERASE : ACT_FLASH_WRITE;
    end else begin
      vrd_nxt.kind = KIND_RANGE;
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      start_r <= '0;
      sum_r   <= '0;
      exph_r  <= '0;
    end else if (accept && active) begin
      pos_r <= pos_eff + 17'd1;
      sum_r <= sum_nxt;
      case (pos_eff)
        17'd4:   cmd_r          <= in_msg_byte;
        17'd5:   len_r[15:8]    <= in_msg_byte;
        17'd6:   len_r[7:0]     <= in_msg_byte;
        17'd7:   start_r[23:16] <= in_msg_byte;
        17'd8:   start_r[15:8]  <= in_msg_byte;
        17'd9:   start_r[7:0]   <= in_msg_byte;
        default: ;
      endcase
      if (pos_eff == lim10) begin
        exph_r <= in_msg_byte;
      end
    end
  end

  // End address, settled before the last checksum byte
  always_ff @(posedge clk) begin
    end_r <= {1'b0, start_r} + {9'd0, len_r};
  end

  // Verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept && final_byte) begin
      vld_r <= 1'b1;
    end else if (vrd_take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_byte) begin
      vrd_r <= vrd_nxt;
    end
  end

  assign vrd_valid = vld_r;
  assign vrd       = vrd_r;

  `WMV_ASSERT_NEXT(a_vrd_hold, vld_r && !vrd_take, vld_r, "verdict dropped before taken")

endmodule

>>> rtl/wmv_emit.sv
module wmv_emit import wmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vrd_valid,
  input  verdict_t    vrd,
  output logic        vrd_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_resp_byte,
  output logic        out_resp_valid,
  output logic        out_resp_last,
  output logic [2:0]  out_action,
  output logic [23:0] out_dest_start,
  output logic [15:0] out_dest_length
);

`include "write_message_validator_assert.svh"

  logic       busy_r;
  logic [3:0] idx_r;
  verdict_t   run_r;

  logic [3:0] run_len;
  logic       last, advance;

  always_comb begin
    case (run_r.kind)
      KIND_MISMATCH: run_len = RUN_MISMATCH;
      KIND_RAM:      run_len = RUN_RAM;
      KIND_FLASH:    run_len = RUN_FLASH;
      default:       run_len = RUN_FAIL;
    endcase
  end

  assign last     = idx_r == (run_len - 4'd1);
  assign advance  = busy_r && out_ready;
  assign vrd_take = vrd_valid && (!busy_r || (advance && last));

  // Run sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (vrd_take) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (advance) begin
      if (last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vrd_take) begin
      run_r <= vrd;
    end
  end

  // Reply byte for the current position
  always_comb begin
    out_resp_byte = RESP_ZERO;
    if (run_r.kind != KIND_FLASH) begin
      case (idx_r)
        4'd0: out_resp_byte = RESP_HDR0;
        4'd1: out_resp_byte = RESP_HDR1;
        4'd2: out_resp_byte = RESP_HDR2;
        4'd3: out_resp_byte = (run_r.kind == KIND_RAM) ? RESP_OK : RESP_FAIL;
        4'd4: out_resp_byte = RESP_WRITE;
        4'd5: begin
          if (run_r.kind == KIND_MISMATCH) out_resp_byte = run_r.sum[15:8];
          else if (run_r.kind == KIND_ODD) out_resp_byte = RESP_ODD;
          else out_resp_byte = RESP_RANGE;
        end
        4'd6: out_resp_byte = (run_r.kind == KIND_MISMATCH) ? run_r.sum[7:0] : RESP_ZERO;
        4'd7: out_resp_byte = run_r.expected[15:8];
        4'd8: out_resp_byte = run_r.expected[7:0];
        4'd9: out_resp_byte = run_r.length[15:8];
        4'd10: out_resp_byte = run_r.length[7:0];
        default: out_resp_byte = RESP_ZERO;
      endcase
    end
  end

  assign out_valid       = busy_r;
  assign out_resp_valid  = run_r.kind != KIND_FLASH;
  assign out_resp_last   = last;
  assign out_action      = run_r.action;
  assign out_dest_start  = (run_r.action != ACT_REJECT) ? run_r.start : 24'd0;
  assign out_dest_length = (run_r.action != ACT_REJECT) ? run_r.length : 16'd0;

  `WMV_ASSERT_IMP(a_idx_range, busy_r, idx_r < run_len, "run index past run length")
  `WMV_ASSERT_NEXT(a_run_step, busy_r && out_ready && !last && !vrd_take,
                   busy_r && (idx_r == $past(idx_r) + 4'd1), "run did not advance")

endmodule
